// ===== src/pct_pkg.sv =====
// Shared types and constants for the pending command tracker.
package pct_pkg;

  // Request function codes.
  localparam logic [1:0] FUNC_ISSUE    = 2'd0;
  localparam logic [1:0] FUNC_RESPONSE = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_ISSUED    = 2'd0;
  localparam logic [1:0] KIND_MATCHED   = 2'd1;
  localparam logic [1:0] KIND_UNMATCHED = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT   = 2'd3;

  // Timeout register and per-tick result limit.
  localparam int unsigned TIMEOUT_W     = 31;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd5000;
  localparam int unsigned CNT_W         = 4;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 4'd8;

  // Input request payload.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  response_id;
    logic [7:0]  sensor_num;
    logic [7:0]  command_code;
    logic [15:0] dest_addr;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot_index;
    logic [7:0]  entry_id;
    logic [7:0]  entry_sensor;
    logic [7:0]  entry_command;
    logic [15:0] entry_target;
    logic        evicted;
    logic [7:0]  evicted_id;
    logic        last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic finish_ok;
  } stat_t;

endpackage

// ===== src/pct_ctrl.sv =====
// Controller state machine: accept, slot scan and finish phases.
module pct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pct_pkg::stat_t  stat_i,
  output pct_pkg::ctrl_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // A new request is taken only between items.
  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.load    = in_valid_i && in_ready_o;
  assign cmd_o.scan    = (state_q == ST_SCAN);
  assign cmd_o.finish  = (state_q == ST_DONE) && stat_i.finish_ok;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.load) state_d = ST_SCAN;
      ST_SCAN: if (stat_i.scan_end) state_d = ST_DONE;
      ST_DONE: if (stat_i.finish_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/pct_dpath.sv =====
// Datapath: slot table, time and sequence counters, scan trackers and result registers.
module pct_dpath #(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pct_pkg::in_t                    in_data_i,
  input  pct_pkg::ctrl_t                  cmd_i,
  output pct_pkg::stat_t                  stat_o,
  input  logic                            cfg_we_i,
  input  logic [pct_pkg::TIMEOUT_W-1:0]   cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pct_pkg::out_t                   out_data_o
);

  localparam int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W = (TIME_BITS > pct_pkg::TIMEOUT_W) ? TIME_BITS
                                                                   : pct_pkg::TIMEOUT_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  // Configuration, counters and the latched request.
  logic [pct_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [TIME_BITS-1:0]          time_q;
  logic [7:0]                    seq_q;
  pct_pkg::in_t                  req_q;

  // Slot table.
  logic [SLOTS-1:0]     valid_q;
  logic [7:0]           id_q     [SLOTS];
  logic [7:0]           sensor_q [SLOTS];
  logic [7:0]           cmdc_q   [SLOTS];
  logic [15:0]          target_q [SLOTS];
  logic [TIME_BITS-1:0] sent_q   [SLOTS];

  // Scan trackers.
  logic [IW-1:0]            idx_q;
  logic                     free_found_q;
  logic [IW-1:0]            free_idx_q;
  logic [TIME_BITS-1:0]     best_age_q;
  logic [IW-1:0]            best_idx_q;
  logic [7:0]               best_id_q;
  logic                     match_q;
  logic [IW-1:0]            match_idx_q;
  logic [pct_pkg::CNT_W-1:0] cnt_q;
  logic                     held_v_q;
  pct_pkg::out_t            held_q;

  // Output register.
  logic          out_v_q;
  pct_pkg::out_t out_q;

  // Per-slot evaluation at the scan index.
  logic [TIME_BITS-1:0] age;
  logic                 cur_valid;
  logic                 tick_hit;
  logic                 out_free;
  logic                 stall;
  logic                 step;
  logic                 finish_ok;
  logic [IW-1:0]        slot_w;
  pct_pkg::out_t        hit_res;

  assign age       = time_q - sent_q[idx_q];
  assign cur_valid = valid_q[idx_q];
  assign tick_hit  = (req_q.func == pct_pkg::FUNC_TICK) && cur_valid &&
                     (CMP_W'(age) > CMP_W'(timeout_q)) && (cnt_q < pct_pkg::MAX_RESULTS);
  assign out_free  = !out_v_q || out_ready_i;
  assign stall     = tick_hit && held_v_q && !out_free;
  assign step      = cmd_i.scan && !stall;
  assign slot_w    = free_found_q ? free_idx_q : best_idx_q;

  assign stat_o.scan_end  = (idx_q == IDX_LAST) && !stall;
  assign stat_o.finish_ok = finish_ok;

  // The finish step waits for a free output register when it has a result to give.
  always_comb begin
    unique case (req_q.func)
      pct_pkg::FUNC_ISSUE,
      pct_pkg::FUNC_RESPONSE: finish_ok = out_free;
      pct_pkg::FUNC_TICK:     finish_ok = !held_v_q || out_free;
      default:                finish_ok = 1'b1;
    endcase
  end

  // Timeout result for the slot under the scan index.
  always_comb begin
    hit_res               = '0;
    hit_res.kind          = pct_pkg::KIND_TIMEOUT;
    hit_res.slot_index    = 3'(idx_q);
    hit_res.entry_id      = id_q[idx_q];
    hit_res.entry_sensor  = sensor_q[idx_q];
    hit_res.entry_command = cmdc_q[idx_q];
    hit_res.entry_target  = target_q[idx_q];
  end

  // Output register load and drain.
  logic          out_load;
  pct_pkg::out_t out_next;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (step && tick_hit && held_v_q) begin
      out_load = 1'b1;
      out_next = held_q;
    end else if (cmd_i.finish) begin
      unique case (req_q.func)
        pct_pkg::FUNC_ISSUE: begin
          out_load            = 1'b1;
          out_next.kind       = pct_pkg::KIND_ISSUED;
          out_next.slot_index = 3'(slot_w);
          out_next.entry_id   = seq_q;
          out_next.evicted    = !free_found_q;
          out_next.evicted_id = free_found_q ? 8'd0 : best_id_q;
          out_next.last       = 1'b1;
        end
        pct_pkg::FUNC_RESPONSE: begin
          out_load          = 1'b1;
          out_next.entry_id = req_q.response_id;
          out_next.last     = 1'b1;
          if (match_q) begin
            out_next.kind       = pct_pkg::KIND_MATCHED;
            out_next.slot_index = 3'(match_idx_q);
          end else begin
            out_next.kind = pct_pkg::KIND_UNMATCHED;
          end
        end
        pct_pkg::FUNC_TICK: begin
          out_load      = held_v_q;
          out_next      = held_q;
          out_next.last = 1'b1;
        end
        default: out_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_next;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Timeout register, time and sequence counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= pct_pkg::TIMEOUT_RESET;
      time_q    <= '0;
      seq_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (cmd_i.load && in_data_i.func == pct_pkg::FUNC_TICK) begin
        time_q <= time_q + TIME_BITS'(1);
      end
      if (cmd_i.load && in_data_i.func == pct_pkg::FUNC_ISSUE) begin
        seq_q <= seq_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
  end

  // Scan control trackers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      free_found_q <= 1'b0;
      match_q      <= 1'b0;
      cnt_q        <= '0;
      held_v_q     <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q        <= '0;
      free_found_q <= 1'b0;
      match_q      <= 1'b0;
      cnt_q        <= '0;
      held_v_q     <= 1'b0;
    end else if (step) begin
      idx_q <= idx_q + IW'(1);
      if (!cur_valid) begin
        free_found_q <= 1'b1;
      end
      if (cur_valid && id_q[idx_q] == req_q.response_id) begin
        match_q <= 1'b1;
      end
      if (tick_hit) begin
        cnt_q    <= cnt_q + pct_pkg::CNT_W'(1);
        held_v_q <= 1'b1;
      end
    end else if (cmd_i.finish) begin
      held_v_q <= 1'b0;
    end
  end

  // Scan data trackers: first free slot, oldest slot, first id match, held timeout.
  always_ff @(posedge clk_i) begin
    if (step) begin
      if (!cur_valid && !free_found_q) begin
        free_idx_q <= idx_q;
      end
      if (idx_q == '0 || age > best_age_q) begin
        best_age_q <= age;
        best_idx_q <= idx_q;
        best_id_q  <= id_q[idx_q];
      end
      if (cur_valid && id_q[idx_q] == req_q.response_id && !match_q) begin
        match_idx_q <= idx_q;
      end
      if (tick_hit) begin
        held_q <= hit_res;
      end
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (step && tick_hit) begin
      valid_q[idx_q] <= 1'b0;
    end else if (cmd_i.finish && req_q.func == pct_pkg::FUNC_ISSUE) begin
      valid_q[slot_w] <= 1'b1;
    end else if (cmd_i.finish && req_q.func == pct_pkg::FUNC_RESPONSE && match_q) begin
      valid_q[match_idx_q] <= 1'b0;
    end
  end

  // Slot contents, written on issue.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && req_q.func == pct_pkg::FUNC_ISSUE) begin
      id_q[slot_w]     <= seq_q;
      sensor_q[slot_w] <= req_q.sensor_num;
      cmdc_q[slot_w]   <= req_q.command_code;
      target_q[slot_w] <= req_q.dest_addr;
      sent_q[slot_w]   <= time_q;
    end
  end

endmodule

// ===== src/pending_command_tracker.sv =====
// Results: an issue or response result is registered after a serial scan over every slot
// and then a finish step; a tick's last timeout is given at the finish step too.
// The serial scan over the slot table means a new request is taken only after the last one
// is finished; a tick that times out several slots also waits while the output is held.
// Each result sits in an output register, so the next request is taken while it waits.
// Reset (rst_ni low, asynchronous) clears valid bits, time, sequence and handshakes; timeout 5000.
module pending_command_tracker #(
  parameter int unsigned SLOTS     = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pct_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pct_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pct_pkg::TIMEOUT_W-1:0] cfg_data_i
);

  pct_pkg::ctrl_t cmd;
  pct_pkg::stat_t stat;

  // Sequencer.
  pct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Slot table and result path.
  pct_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
